/* src/gcnms_pkg.sv */
// Shared types and constants for the class-aware suppression block.
package gcnms_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int MAX_BOXES  = 4096;
  localparam int KEPT_W     = $clog2(MAX_KEPT);
  localparam int CNT_W      = $clog2(MAX_KEPT + 1);
  localparam int NUM_W      = $clog2(MAX_BOXES);
  localparam int PIPE_DEPTH = 4;
  localparam logic [7:0] THR_RESET = 8'd115;
  localparam logic [1:0] ADDR_THR  = 2'd0;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [6:0]         class_label;
    logic               first_box;
    logic               last_box;
  } box_in_t;

  typedef struct packed {
    logic [11:0] box_number;
    logic        keep;
    logic        list_full;
    logic        frame_end;
  } result_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [6:0]         cls;
    logic [29:0]        area;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

/* src/gcnms_cell.sv */
// One slot of the retained-box ring.
module gcnms_cell (
  input  logic              clk,
  input  logic              shift,
  input  logic              load,
  input  gcnms_pkg::entry_t nbr,
  input  gcnms_pkg::entry_t load_data,
  output gcnms_pkg::entry_t ent
);

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_data;
    end else if (shift) begin
      ent <= nbr;
    end
  end

endmodule

/* src/gcnms_cmp.sv */
// Pipelined overlap test of the new box against one retained box.
module gcnms_cmp (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  gcnms_pkg::entry_t  ent,
  input  gcnms_pkg::box_in_t box,
  input  logic [29:0]        box_area,
  input  logic [7:0]         thr,
  output logic               hit
);

  logic signed [17:0] l_a, l_b, r_a, r_b, t_a, t_b, b_a, b_b;
  logic signed [17:0] dx, dy;
  logic               v1, v2, v3;
  logic [14:0]        dx1, dy1;
  logic [29:0]        karea1, karea2;
  logic [29:0]        inter2, inter3;
  logic [30:0]        uni3;
  logic [38:0]        lhs, rhs;

  always_comb begin
    l_a = 18'(box.box_left);
    l_b = 18'(ent.left);
    r_a = l_a + $signed({3'b000, box.box_width});
    r_b = l_b + $signed({3'b000, ent.width});
    t_a = 18'(box.box_top);
    t_b = 18'(ent.top);
    b_a = t_a + $signed({3'b000, box.box_height});
    b_b = t_b + $signed({3'b000, ent.height});
    dx  = ((r_a < r_b) ? r_a : r_b) - ((l_a > l_b) ? l_a : l_b);
    dy  = ((b_a < b_b) ? b_a : b_b) - ((t_a > t_b) ? t_a : t_b);
    lhs = {1'b0, inter3, 8'd0};
    rhs = 39'(thr) * 39'(uni3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= valid_in && (ent.cls == box.class_label);
      v2  <= v1;
      v3  <= v2;
      hit <= v3 && (uni3 != '0) && (lhs > rhs);
    end
  end

  always_ff @(posedge clk) begin
    dx1    <= dx[17] ? '0 : dx[14:0];
    dy1    <= dy[17] ? '0 : dy[14:0];
    karea1 <= ent.area;
    inter2 <= dx1 * dy1;
    karea2 <= karea1;
    inter3 <= inter2;
    uni3   <= 31'(box_area) + 31'(karea2) - 31'(inter2);
  end

endmodule

/* src/greedy_class_aware_nms_top.sv */
// Top level of the class-aware greedy suppression block.
// The retained boxes rotate through a ring of cells past one comparator, one per cycle.
// busy stays high while a word is in flight, until the done strobe; a new word can start in the cycle done is high.
// Synchronous reset empties the list, zeroes the box counter and sets the threshold to 115.
module greedy_class_aware_nms_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gcnms_pkg::box_in_t box,
  output logic               done,
  output gcnms_pkg::result_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int N = gcnms_pkg::MAX_KEPT;

  gcnms_pkg::state_t state, state_next;
  gcnms_pkg::box_in_t box_reg;
  gcnms_pkg::entry_t  ent [N];
  gcnms_pkg::entry_t  new_ent;
  logic [7:0]                   thr;
  logic [29:0]                  box_area;
  logic [gcnms_pkg::CNT_W-1:0]  kept_count;
  logic [gcnms_pkg::CNT_W-1:0]  idx;
  logic [gcnms_pkg::NUM_W-1:0]  box_counter, number;
  logic                         hit_acc, cmp_hit;
  logic                         issue, finish, accept, full;

  assign pready = 1'b1;
  assign prdata = {24'd0, thr};
  assign accept = start && !busy;
  assign full   = (kept_count == gcnms_pkg::CNT_W'(N));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gcnms_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == gcnms_pkg::ADDR_THR)) begin
      thr <= pwdata[7:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gcnms_pkg::ST_IDLE:  if (start) state_next = gcnms_pkg::ST_SCAN;
      gcnms_pkg::ST_SCAN:  if (idx == gcnms_pkg::CNT_W'(N - 1)) state_next = gcnms_pkg::ST_DRAIN;
      gcnms_pkg::ST_DRAIN: begin
        if (idx == gcnms_pkg::CNT_W'(gcnms_pkg::PIPE_DEPTH - 1)) begin
          state_next = gcnms_pkg::ST_DONE;
        end
      end
      gcnms_pkg::ST_DONE:  state_next = gcnms_pkg::ST_IDLE;
      default:             state_next = gcnms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state)
      gcnms_pkg::ST_IDLE: busy   = 1'b0;
      gcnms_pkg::ST_SCAN: issue  = 1'b1;
      gcnms_pkg::ST_DONE: finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gcnms_pkg::ST_IDLE;
      idx         <= '0;
      kept_count  <= '0;
      box_counter <= '0;
      hit_acc     <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state_next != state) begin
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
      if (accept) begin
        hit_acc <= 1'b0;
        if (box.first_box) begin
          kept_count  <= '0;
          box_counter <= gcnms_pkg::NUM_W'(1);
        end else if (box_counter == gcnms_pkg::NUM_W'(gcnms_pkg::MAX_BOXES - 1)) begin
          box_counter <= '0;
        end else begin
          box_counter <= box_counter + 1'b1;
        end
      end else if (cmp_hit) begin
        hit_acc <= 1'b1;
      end
      if (finish && !hit_acc && !full) begin
        kept_count <= kept_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      box_reg <= box;
      number  <= box.first_box ? '0 : box_counter;
    end
    box_area <= box_reg.box_width * box_reg.box_height;
    if (finish) begin
      result.box_number <= 12'(number);
      result.keep       <= !hit_acc;
      result.list_full  <= !hit_acc && full;
      result.frame_end  <= box_reg.last_box;
    end
  end

  always_comb begin
    new_ent.left   = box_reg.box_left;
    new_ent.top    = box_reg.box_top;
    new_ent.width  = box_reg.box_width;
    new_ent.height = box_reg.box_height;
    new_ent.cls    = box_reg.class_label;
    new_ent.area   = box_area;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    gcnms_cell u_cell (
      .clk       (clk),
      .shift     (issue),
      .load      (finish && !hit_acc && !full &&
                  (kept_count[gcnms_pkg::KEPT_W-1:0] == gcnms_pkg::KEPT_W'(i))),
      .nbr       (ent[(i + 1) % N]),
      .load_data (new_ent),
      .ent       (ent[i])
    );
  end

  gcnms_cmp u_cmp (
    .clk      (clk),
    .rst      (rst),
    .valid_in (issue && (idx < kept_count)),
    .ent      (ent[0]),
    .box      (box_reg),
    .box_area (box_area),
    .thr      (thr),
    .hit      (cmp_hit)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    kept_count <= gcnms_pkg::CNT_W'(N))
    else $error("Retained count exceeds capacity.");

  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.keep || !result.list_full))
    else $error("List full reported on a suppressed word.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe lasted more than one cycle.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Block not busy after accepting a word.");

endmodule

/* tb/greedy_class_aware_nms_top_test.sv */
// Testbench for the class-aware suppression block: directed and random boxes checked against a predictor.
`timescale 1ns / 1ps

module greedy_class_aware_nms_top_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  gcnms_pkg::box_in_t box = '0;
  logic done;
  gcnms_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  greedy_class_aware_nms_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box(box), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gcnms_pkg::box_in_t pending_boxes[$];
  gcnms_pkg::result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int watchdog = 0;
  bit quiet_phase = 0;
  bit hold_driver = 0;

  logic signed [15:0] kept_left[gcnms_pkg::MAX_KEPT];
  logic signed [15:0] kept_top[gcnms_pkg::MAX_KEPT];
  logic [14:0] kept_w[gcnms_pkg::MAX_KEPT];
  logic [14:0] kept_h[gcnms_pkg::MAX_KEPT];
  logic [6:0] kept_cls[gcnms_pkg::MAX_KEPT];
  int kept_num = 0;
  logic [11:0] frame_pos = '0;
  logic [7:0] threshold = gcnms_pkg::THR_RESET;

  function automatic gcnms_pkg::result_t suppress_box(gcnms_pkg::box_in_t b);
    gcnms_pkg::result_t r;
    longint l, t, w, h, bl, bt, bw, bh, dx, dy, inter, uni;
    bit keep_it;
    if (b.first_box) begin
      kept_num = 0;
      frame_pos = '0;
    end
    r.box_number = frame_pos;
    frame_pos = frame_pos + 12'd1;
    l = b.box_left;
    t = b.box_top;
    w = b.box_width;
    h = b.box_height;
    keep_it = 1;
    for (int i = 0; i < kept_num; i++) begin
      if (kept_cls[i] == b.class_label) begin
        bl = kept_left[i];
        bt = kept_top[i];
        bw = kept_w[i];
        bh = kept_h[i];
        dx = ((l + w < bl + bw) ? l + w : bl + bw) - ((l > bl) ? l : bl);
        dy = ((t + h < bt + bh) ? t + h : bt + bh) - ((t > bt) ? t : bt);
        if (dx < 0) dx = 0;
        if (dy < 0) dy = 0;
        inter = dx * dy;
        uni = w * h + bw * bh - inter;
        if (uni > 0 && inter * 256 > longint'(threshold) * uni) begin
          keep_it = 0;
          break;
        end
      end
    end
    r.keep = keep_it;
    r.list_full = 1'b0;
    if (keep_it) begin
      if (kept_num < gcnms_pkg::MAX_KEPT) begin
        kept_left[kept_num] = b.box_left;
        kept_top[kept_num] = b.box_top;
        kept_w[kept_num] = b.box_width;
        kept_h[kept_num] = b.box_height;
        kept_cls[kept_num] = b.class_label;
        kept_num++;
      end else begin
        r.list_full = 1'b1;
      end
    end
    r.frame_end = b.last_box;
    return r;
  endfunction

  function automatic gcnms_pkg::box_in_t make_box(int l, int t, int w, int h, int c, bit f,
                                                  bit e);
    gcnms_pkg::box_in_t b;
    b.box_left = l[15:0];
    b.box_top = t[15:0];
    b.box_width = w[14:0];
    b.box_height = h[14:0];
    b.class_label = c[6:0];
    b.first_box = f;
    b.last_box = e;
    return b;
  endfunction

  task automatic add_box(gcnms_pkg::box_in_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_cycles <= 0;
    end else if (start && !busy) begin
      expected_results.insert(expected_results.size(), suppress_box(box));
      if (pending_boxes.size() > 0 && !hold_driver &&
          (quiet_phase || $urandom_range(0, 9) != 0)) begin
        box <= pending_boxes.pop_front();
      end else begin
        start <= 1'b0;
        idle_cycles <= quiet_phase ? 0 : $urandom_range(1, 13);
      end
    end else if (!start) begin
      if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
      end else if (pending_boxes.size() > 0 && !hold_driver) begin
        box <= pending_boxes.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", result);
      end else begin
        gcnms_pkg::result_t want;
        want = expected_results.pop_front();
        if (want !== result) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected number %0d keep %b full %b end %b, got %0d %b %b %b",
                     want.box_number, want.keep, want.list_full, want.frame_end,
                     result.box_number, result.keep, result.list_full, result.frame_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || hold_driver) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_threshold(logic [7:0] value);
    while (start || pending_boxes.size() > 0 || expected_results.size() > 0) @(posedge clk);
    hold_driver = 1;
    repeat (80) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= gcnms_pkg::ADDR_THR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    threshold = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hold_driver = 0;
  endtask

  task automatic queue_frame(int n, bit tight);
    int cx, cy, base_w, base_h, ncls;
    cx = $urandom_range(0, 2000) - 1000;
    cy = $urandom_range(0, 2000) - 1000;
    base_w = $urandom_range(16, 800);
    base_h = $urandom_range(16, 800);
    ncls = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (tight || $urandom_range(0, 4) != 0) begin
        add_box(make_box(cx + $urandom_range(0, 200) - 100,
          cy + $urandom_range(0, 200) - 100, base_w + $urandom_range(0, 100),
          base_h + $urandom_range(0, 100), $urandom_range(0, ncls - 1), i == 0, i == n - 1));
      end else begin
        add_box(make_box($urandom_range(0, 65535), $urandom_range(0, 65535),
          $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 127),
          (i == 0) || ($urandom_range(0, 30) == 0), (i == n - 1) || ($urandom_range(0, 30) == 0)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_box(make_box(0, 0, 160, 160, 0, 1, 0));
    add_box(make_box(8, 8, 160, 160, 0, 0, 0));
    add_box(make_box(8, 8, 160, 160, 1, 0, 0));
    add_box(make_box(0, 0, 0, 0, 2, 0, 0));
    add_box(make_box(0, 0, 0, 0, 2, 0, 0));
    add_box(make_box(0, 0, 0, 50, 0, 0, 0));
    add_box(make_box(-32768, -32768, 32767, 32767, 127, 0, 0));
    add_box(make_box(32767, 32767, 32767, 32767, 127, 0, 0));
    add_box(make_box(-32768, 32767, 0, 32767, 127, 0, 1));
    add_box(make_box(100, 100, 10, 10, 5, 0, 0));
    add_box(make_box(100, 100, 10, 10, 5, 1, 1));
    write_threshold(8'd0);
    add_box(make_box(0, 0, 100, 100, 3, 1, 0));
    add_box(make_box(99, 99, 100, 100, 3, 0, 0));
    add_box(make_box(100, 0, 100, 100, 3, 0, 1));
    write_threshold(8'd255);
    add_box(make_box(0, 0, 100, 100, 3, 1, 0));
    add_box(make_box(0, 0, 100, 100, 3, 0, 1));
    for (int i = 0; i < 70; i++)
      add_box(make_box(i * 300, 0, 100, 100, 9, i == 0, i == 69));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_threshold(8'd26);
        1: write_threshold(8'd230);
        2: write_threshold(8'd115);
        3: write_threshold(8'($urandom_range(0, 255)));
        4: write_threshold(8'd1);
        default: write_threshold(8'd180);
      endcase
      if (phase == 5) quiet_phase = 1;
      while (pending_boxes.size() < 230)
        queue_frame($urandom_range(1, 80), $urandom_range(0, 3) == 0);
    end
    if (pending_boxes.size() > 0) begin
      hold_driver = 0;
      while (pending_boxes.size() > 0 || start) @(posedge clk);
    end
    while (expected_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
